### rtl/temperature_to_decimal_text_macros.svh
//------------------------------------------------------------------------------
// Assertion macros for the temperature text block.
// Each macro becomes a labelled concurrent assertion in simulation and
// nothing at all when the design is synthesised.
//------------------------------------------------------------------------------
`ifndef TEMPERATURE_TO_DECIMAL_TEXT_MACROS_SVH
`define TEMPERATURE_TO_DECIMAL_TEXT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define TTDT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define TTDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TTDT_ASSERT_SAME(label, clk, rst, ante, cons)
`define TTDT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/ttdt_pkg.sv
//------------------------------------------------------------------------------
// Temperature text package
// Widths, character codes, byte positions, display columns and reciprocal constants.
//------------------------------------------------------------------------------
package ttdt_pkg;

   localparam int RAW_W    = 12;
   localparam int MAG_W    = 12;
   localparam int SCALED_W = 16;
   localparam int HUND_W   = 14;
   localparam int Q100_W   = 8;
   localparam int REM_W    = 7;
   localparam int DIGIT_W  = 4;
   localparam int BYTE_W   = 8;
   localparam int COL_W    = 3;
   localparam int SUFFIX_W = 48;
   localparam int SFX_SEL_W = 3;

   // Reciprocal of 100: floor(h * 5243 / 2^19) is exact for h below 43699.
   localparam int RECIP100_W     = 13;
   localparam int PROD100_W      = HUND_W + RECIP100_W;
   localparam logic [RECIP100_W-1:0] RECIP100 = 13'd5243;
   // Reciprocal of 10: floor(x * 205 / 2^11) is exact for x below 1029.
   localparam int PROD10_W       = 15;
   localparam logic [PROD10_W-1:0] RECIP10 = 15'd205;
   localparam int RECIP10_SHIFT  = 11;

   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

   // Byte positions within one run.
   localparam int POS_SIGN    = 0;
   localparam int POS_HUNDREDS = 1;
   localparam int POS_TENS    = 2;
   localparam int POS_UNITS   = 3;
   localparam int POS_POINT   = 4;
   localparam int POS_TENTHS  = 5;
   localparam int POS_HUNDTHS = 6;
   localparam int POS_SUFFIX0 = 7;

   // Display columns of the display bytes.
   localparam logic [COL_W-1:0] COL_SIGN     = 3'd0;
   localparam logic [COL_W-1:0] COL_HUNDREDS = 3'd2;
   localparam logic [COL_W-1:0] COL_TENS     = 3'd3;
   localparam logic [COL_W-1:0] COL_UNITS    = 3'd4;
   localparam logic [COL_W-1:0] COL_POINT    = 3'd5;
   localparam logic [COL_W-1:0] COL_TENTHS   = 3'd6;
   localparam logic [COL_W-1:0] COL_HUNDTHS  = 3'd7;

   typedef logic [DIGIT_W-1:0] digit_type;

endpackage

### rtl/temperature_to_decimal_text.sv
//------------------------------------------------------------------------------
// Temperature to decimal text
// Turns a signed reading in sixteenths of a degree into a run of text beats.
//------------------------------------------------------------------------------
// A reading is taken when start is high and busy is low. It produces a run of
// 7 + SUFFIX_COUNT beats (13 by default), one beat per cycle with no gaps,
// each marked by rsp_strobe for exactly one cycle: sign, three integer digits,
// point, two fraction digits, then the configured suffix bytes. The receiver
// cannot hold beats off, so it must take one every cycle while rsp_strobe is
// high. The single output byte lane limits the sustained rate: a new run
// starts only after the last beat of the one before. Readings may be offered
// back to back: a six-stage arithmetic pipeline holds later readings while
// a run is still being sent, and busy rises only once that pipeline is full.
// Each reading's beats leave from the serialiser through the output register.
// The suffix register should be written only while the block is idle.
//------------------------------------------------------------------------------
`include "temperature_to_decimal_text_macros.svh"

module temperature_to_decimal_text
   import ttdt_pkg::*;
#(
   parameter int SUFFIX_COUNT = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [RAW_W-1:0]  req_raw_reading,
   input  logic                     csr_wr_en,
   input  logic [SUFFIX_W-1:0]      csr_wr_data,
   output logic                     rsp_strobe,
   output logic [BYTE_W-1:0]        rsp_out_byte,
   output logic                     rsp_to_display,
   output logic [COL_W-1:0]         rsp_display_column,
   output logic                     rsp_last
);

   // Length of one run and the width of the position counter that walks it.
   localparam int RUN_LEN  = POS_SUFFIX0 + SUFFIX_COUNT;
   localparam int IDX_W    = $clog2(RUN_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RUN_LEN - 1);
   // Set when the run ends on the last fraction digit.
   localparam logic NO_SUFFIX = (SUFFIX_COUNT == 0);

   // The suffix register. It feeds the byte selection for the suffix positions.
   logic [SUFFIX_W-1:0] suffix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         suffix_ff <= '0;
      end else if (csr_wr_en) begin
         suffix_ff <= csr_wr_data;
      end
   end

   // Stage enables. A stage loads when it is empty or when its contents move on;
   // the serialiser at the end is the only place that can hold things up.
   logic ser_free;
   logic en1, en2, en3, en4, en5, en6;
   logic req_accept;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   assign en6 = !v6_ff || ser_free;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign busy       = !en1;
   assign req_accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_accept;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
         if (en6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   // Stage 1: sign and magnitude. The two's complement negate of -2048 wraps
   // to 0x800, which read unsigned is exactly the magnitude 2048.
   logic [RAW_W-1:0] raw_bits;
   logic             neg1_in, neg1_ff;
   logic [MAG_W-1:0] mag1_in, mag1_ff;

   assign raw_bits = unsigned'(req_raw_reading);
   assign neg1_in  = raw_bits[RAW_W-1];
   assign mag1_in  = neg1_in ? MAG_W'(~raw_bits + 1'b1) : raw_bits;

   // Stage 2: hundredths of a degree, rounded half up: (m * 25 + 2) >> 2.
   logic [SCALED_W-1:0] scaled2;
   logic                neg2_ff;
   logic [HUND_W-1:0]   hund2_in, hund2_ff;

   assign scaled2  = SCALED_W'(mag1_ff) * SCALED_W'(25) + SCALED_W'(2);
   assign hund2_in = scaled2[HUND_W+1:2];

   // Stage 3: quotient by 100 through the reciprocal.
   logic [PROD100_W-1:0] prod3;
   logic                 neg3_ff;
   logic [HUND_W-1:0]    hund3_ff;
   logic [Q100_W-1:0]    q100_3_in, q100_3_ff;

   assign prod3     = PROD100_W'(hund2_ff) * PROD100_W'(RECIP100);
   assign q100_3_in = prod3[PROD100_W-1 -: Q100_W];

   // Stage 4: the fraction part (h mod 100), the leading digit and what is
   // left of the integer part below 100.
   logic              neg4_ff;
   logic              lead4_in, lead4_ff;
   logic [REM_W-1:0]  int4_in, int4_ff;
   logic [REM_W-1:0]  frac4_in, frac4_ff;

   assign lead4_in = (q100_3_ff >= Q100_W'(100));
   assign int4_in  = REM_W'(q100_3_ff - (lead4_in ? Q100_W'(100) : Q100_W'(0)));
   assign frac4_in = REM_W'(hund3_ff - HUND_W'(q100_3_ff) * HUND_W'(100));

   // Stage 5: tens of both two-digit parts through the reciprocal of 10.
   logic [PROD10_W-1:0] int_prod5, frac_prod5;
   logic                neg5_ff, lead5_ff;
   logic [REM_W-1:0]    int5_ff, frac5_ff;
   digit_type           int_tens5_in, int_tens5_ff;
   digit_type           frac_tens5_in, frac_tens5_ff;

   assign int_prod5     = PROD10_W'(int4_ff) * RECIP10;
   assign frac_prod5    = PROD10_W'(frac4_ff) * RECIP10;
   assign int_tens5_in  = int_prod5[RECIP10_SHIFT +: DIGIT_W];
   assign frac_tens5_in = frac_prod5[RECIP10_SHIFT +: DIGIT_W];

   // Stage 6: units of both parts.
   logic      neg6_ff, lead6_ff;
   digit_type int_tens6_ff, frac_tens6_ff;
   digit_type int_units6_in, int_units6_ff;
   digit_type frac_units6_in, frac_units6_ff;

   assign int_units6_in  = DIGIT_W'(int5_ff - REM_W'(int_tens5_ff) * REM_W'(10));
   assign frac_units6_in = DIGIT_W'(frac5_ff - REM_W'(frac_tens5_ff) * REM_W'(10));

   // Pipeline payload registers move with their stage enables.
   always_ff @(posedge clock) begin
      if (en1) begin
         neg1_ff <= neg1_in;
         mag1_ff <= mag1_in;
      end
      if (en2) begin
         neg2_ff  <= neg1_ff;
         hund2_ff <= hund2_in;
      end
      if (en3) begin
         neg3_ff   <= neg2_ff;
         hund3_ff  <= hund2_ff;
         q100_3_ff <= q100_3_in;
      end
      if (en4) begin
         neg4_ff  <= neg3_ff;
         lead4_ff <= lead4_in;
         int4_ff  <= int4_in;
         frac4_ff <= frac4_in;
      end
      if (en5) begin
         neg5_ff       <= neg4_ff;
         lead5_ff      <= lead4_ff;
         int5_ff       <= int4_ff;
         frac5_ff      <= frac4_ff;
         int_tens5_ff  <= int_tens5_in;
         frac_tens5_ff <= frac_tens5_in;
      end
      if (en6) begin
         neg6_ff        <= neg5_ff;
         lead6_ff       <= lead5_ff;
         int_tens6_ff   <= int_tens5_ff;
         frac_tens6_ff  <= frac_tens5_ff;
         int_units6_ff  <= int_units6_in;
         frac_units6_ff <= frac_units6_in;
      end
   end

   // Serialiser. It holds one reading's digits and walks the byte positions.
   // It can take the next reading on the cycle in which it sends the last beat
   // of the current run, so a waiting reading's run follows without a gap.
   logic             ser_act_ff;
   logic [IDX_W-1:0] ser_idx_ff;
   logic             ser_load;
   logic             ser_neg_ff;
   digit_type        ser_dig_ff [5];

   assign ser_free = !ser_act_ff || (ser_idx_ff == LAST_IDX);
   assign ser_load = v6_ff && ser_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_act_ff <= 1'b0;
         ser_idx_ff <= '0;
      end else if (ser_load) begin
         ser_act_ff <= 1'b1;
         ser_idx_ff <= '0;
      end else if (ser_act_ff) begin
         if (ser_idx_ff == LAST_IDX) begin
            ser_act_ff <= 1'b0;
         end
         ser_idx_ff <= ser_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_neg_ff    <= neg6_ff;
         ser_dig_ff[0] <= DIGIT_W'(lead6_ff);
         ser_dig_ff[1] <= int_tens6_ff;
         ser_dig_ff[2] <= int_units6_ff;
         ser_dig_ff[3] <= frac_tens6_ff;
         ser_dig_ff[4] <= frac_units6_ff;
      end
   end

   // Byte selection for the current position.
   logic [SFX_SEL_W-1:0] sfx_sel;
   logic [BYTE_W-1:0]    byte_in;
   logic                 disp_in;
   logic [COL_W-1:0]     col_in;

   assign sfx_sel = SFX_SEL_W'(ser_idx_ff - IDX_W'(POS_SUFFIX0));

   always_comb begin
      disp_in = 1'b1;
      unique case (ser_idx_ff)
         IDX_W'(POS_SIGN): begin
            byte_in = ser_neg_ff ? CHAR_MINUS : CHAR_PLUS;
            col_in  = COL_SIGN;
         end
         IDX_W'(POS_HUNDREDS): begin
            byte_in = CHAR_ZERO + BYTE_W'(ser_dig_ff[0]);
            col_in  = COL_HUNDREDS;
         end
         IDX_W'(POS_TENS): begin
            byte_in = CHAR_ZERO + BYTE_W'(ser_dig_ff[1]);
            col_in  = COL_TENS;
         end
         IDX_W'(POS_UNITS): begin
            byte_in = CHAR_ZERO + BYTE_W'(ser_dig_ff[2]);
            col_in  = COL_UNITS;
         end
         IDX_W'(POS_POINT): begin
            byte_in = CHAR_POINT;
            col_in  = COL_POINT;
         end
         IDX_W'(POS_TENTHS): begin
            byte_in = CHAR_ZERO + BYTE_W'(ser_dig_ff[3]);
            col_in  = COL_TENTHS;
         end
         IDX_W'(POS_HUNDTHS): begin
            byte_in = CHAR_ZERO + BYTE_W'(ser_dig_ff[4]);
            col_in  = COL_HUNDTHS;
         end
         default: begin
            // Suffix bytes go to the serial link only and carry column zero.
            byte_in = suffix_ff[{sfx_sel, 3'b000} +: BYTE_W];
            disp_in = 1'b0;
            col_in  = COL_SIGN;
         end
      endcase
   end

   // Output register: one beat per cycle while the serialiser is active.
   logic             rsp_strobe_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic             rsp_disp_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         rsp_strobe_ff <= ser_act_ff;
         rsp_last_ff   <= ser_act_ff && (ser_idx_ff == LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= byte_in;
      rsp_disp_ff <= disp_in;
      rsp_col_ff  <= col_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_to_display     = rsp_disp_ff;
   assign rsp_display_column = rsp_col_ff;
   assign rsp_last           = rsp_last_ff;

   // A run is sent without gaps: every beat but the last is followed by another.
   `TTDT_ASSERT_NEXT(a_run_contiguous, clock, reset, rsp_strobe && !rsp_last, rsp_strobe)
   // The end-of-run mark only ever rides on a beat.
   `TTDT_ASSERT_SAME(a_last_on_beat, clock, reset, rsp_last, rsp_strobe)
   // The final beat is a display byte only when there is no suffix.
   `TTDT_ASSERT_SAME(a_last_kind, clock, reset, rsp_last, rsp_to_display == NO_SUFFIX)
   // Column one is never used on the display.
   `TTDT_ASSERT_SAME(a_column_gap, clock, reset, rsp_to_display, rsp_display_column != COL_W'(1))

endmodule
